FILE: sv/rscs_pkg.sv
package rscs_pkg;

    // Series store depth and sample width.
    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_W    = 32;

    // Count of stored samples, the prefix run of signs and the split sums.
    localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int RUN_W   = COUNT_W + 1;
    localparam int SUM_W   = 20;
    localparam int STAT_W  = 19;

    // Token that travels down the row of cells, one cell per cycle while the row is not halted.
    typedef struct packed {
        logic                       valid;
        logic                       first;
        logic                       dropped;
        logic                       stored;
        logic signed [SAMPLE_W-1:0] key;
        logic signed [RUN_W-1:0]    run;
        logic [STAT_W-1:0]          peak;
        logic [COUNT_W-1:0]         count;
    } t_token;

    // One finished result as held in the output buffer.
    typedef struct packed {
        logic [STAT_W-1:0]  doubled_stat;
        logic [STAT_W-1:0]  best_doubled;
        logic [COUNT_W-1:0] sample_count;
        logic               full_res;
    } t_result;

endpackage

FILE: sv/rscs_if.sv
// Input channel: one sample and the new-series flag per item.
interface rscs_in_if import rscs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;

    modport source (output valid, output sample, output first, input ready);
    modport sink (input valid, input sample, input first, output ready);
endinterface

// Output channel: one result per input item.
interface rscs_out_if import rscs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  doubled_stat;
    logic [STAT_W-1:0]  best_doubled;
    logic [COUNT_W-1:0] sample_count;
    logic               full_res;

    modport source (output valid, output doubled_stat, output best_doubled,
                    output sample_count, output full_res, input ready);
    modport sink (input valid, input doubled_stat, input best_doubled,
                  input sample_count, input full_res, output ready);
endinterface

FILE: sv/rscs_cell.sv
module rscs_cell import rscs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_token i_tok,
    output t_token o_tok
);

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SUM_W-1:0]    r_sum;
    t_token                     r_tok;

    logic                       n_valid;
    logic signed [SAMPLE_W-1:0] n_sample;
    logic signed [SUM_W-1:0]    n_sum;
    t_token                     n_tok;

    logic signed [RUN_W-1:0]    w_run;
    logic signed [SUM_W-1:0]    w_sum_new;
    logic signed [SUM_W-1:0]    w_neg;
    logic [STAT_W-1:0]          w_mag_old;
    logic [STAT_W-1:0]          w_mag_new;

    // Sign of (held sample minus passing sample) added to the prefix run.
    always_comb begin
        if (r_sample > i_tok.key) begin
            w_run = i_tok.run + RUN_W'(1);
        end else if (r_sample < i_tok.key) begin
            w_run = i_tok.run - RUN_W'(1);
        end else begin
            w_run = i_tok.run;
        end
    end

    // The split after this cell gains the run; magnitudes fit the stat width.
    assign w_sum_new = r_sum + {{(SUM_W - RUN_W){w_run[RUN_W-1]}}, w_run};

    always_comb begin
        w_neg     = -r_sum;
        w_mag_old = r_sum[SUM_W-1] ? w_neg[STAT_W-1:0] : r_sum[STAT_W-1:0];
        w_neg     = -w_sum_new;
        w_mag_new = w_sum_new[SUM_W-1] ? w_neg[STAT_W-1:0] : w_sum_new[STAT_W-1:0];
    end

    // Cell update for the passing item.
    always_comb begin
        n_tok    = i_tok;
        n_valid  = r_valid;
        n_sample = r_sample;
        n_sum    = r_sum;
        if (i_tok.valid) begin
            if (i_tok.first) begin
                // A new series lands in the first cell and empties the rest.
                if (!i_tok.stored) begin
                    n_valid      = 1'b1;
                    n_sample     = i_tok.key;
                    n_sum        = '0;
                    n_tok.stored = 1'b1;
                end else begin
                    n_valid = 1'b0;
                end
            end else if (r_valid) begin
                if (i_tok.dropped) begin
                    if (w_mag_old > i_tok.peak) begin
                        n_tok.peak = w_mag_old;
                    end
                end else begin
                    n_sum     = w_sum_new;
                    n_tok.run = w_run;
                    if (w_mag_new > i_tok.peak) begin
                        n_tok.peak = w_mag_new;
                    end
                end
            end else if (!i_tok.stored) begin
                // First empty cell takes the sample; its split starts at zero.
                n_valid      = 1'b1;
                n_sample     = i_tok.key;
                n_sum        = '0;
                n_tok.stored = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_valid  <= n_valid;
            r_sample <= n_sample;
            r_sum    <= n_sum;
            r_tok    <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: sv/rscs_out_buf.sv
module rscs_out_buf import rscs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_result         i_data,
    output logic            o_full,
    rscs_out_if.source      o_out
);

    t_result    r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    logic       w_pop;
    t_result    w_head;

    assign w_pop  = o_out.valid && o_out.ready;
    assign w_head = r_data[r_rd_ptr];

    // Two-entry result queue; pointers wrap on one bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !w_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (w_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_full             = r_fill[1];
    assign o_out.valid        = (r_fill != 2'd0);
    assign o_out.doubled_stat = w_head.doubled_stat;
    assign o_out.best_doubled = w_head.best_doubled;
    assign o_out.sample_count = w_head.sample_count;
    assign o_out.full_res     = w_head.full_res;

endmodule

FILE: sv/rank_sum_changepoint_scan_top.sv
// Rank-sum change-point scan. Each input item is one signed sample and a
// flag that starts a new series; each yields one result with the largest
// absolute split sum (twice the statistic), its running maximum over the
// series, the stored sample count and a flag for a sample dropped because
// MAX_SAMPLES samples are already held. The series lives in a row of
// MAX_SAMPLES cells, one sample and one split sum per cell; an item walks
// the row one cell per cycle while the row is not halted, and a new item
// can enter every cycle while the row is not halted. Items in flight
// follow each other down the row in order. A two-entry output queue keeps
// the row moving while a result waits; the row halts only while that queue
// is full.
module rank_sum_changepoint_scan_top import rscs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rscs_in_if.sink    i_in,
    rscs_out_if.source o_out
);

    logic [COUNT_W-1:0] r_count;
    logic [STAT_W-1:0]  r_best;

    logic [COUNT_W-1:0] n_count;
    logic               w_dropped;
    logic               w_en;
    logic               w_accept;
    logic               w_full;
    logic               w_push;
    logic [STAT_W-1:0]  w_best;
    t_token             w_tok [MAX_SAMPLES+1];
    t_result            w_res;

    assign w_en       = !w_full;
    assign i_in.ready = w_en;
    assign w_accept   = i_in.valid && w_en;

    // Stored count after this item; a full store drops the sample.
    always_comb begin
        w_dropped = 1'b0;
        if (i_in.first) begin
            n_count = COUNT_W'(1);
        end else if (r_count == COUNT_W'(MAX_SAMPLES)) begin
            n_count   = r_count;
            w_dropped = 1'b1;
        end else begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Token that enters the first cell.
    always_comb begin
        w_tok[0].valid   = w_accept;
        w_tok[0].first   = i_in.first;
        w_tok[0].dropped = w_dropped;
        w_tok[0].stored  = 1'b0;
        w_tok[0].key     = i_in.sample;
        w_tok[0].run     = '0;
        w_tok[0].peak    = '0;
        w_tok[0].count   = n_count;
    end

    // Row of cells.
    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        rscs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // Running maximum over the series, taken as each item leaves the row.
    assign w_push = w_en && w_tok[MAX_SAMPLES].valid;

    always_comb begin
        if (w_tok[MAX_SAMPLES].first || (w_tok[MAX_SAMPLES].peak > r_best)) begin
            w_best = w_tok[MAX_SAMPLES].peak;
        end else begin
            w_best = r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (w_push) begin
            r_best <= w_best;
        end
    end

    assign w_res.doubled_stat = w_tok[MAX_SAMPLES].peak;
    assign w_res.best_doubled = w_best;
    assign w_res.sample_count = w_tok[MAX_SAMPLES].count;
    assign w_res.full_res     = w_tok[MAX_SAMPLES].dropped;

    rscs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_out   (o_out)
    );

endmodule

FILE: dv/rank_scan_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the change-point scan, keeps its own copy of the
// series and of the split sums, and checks every result against the oldest
// outstanding prediction.
module rank_scan_checker import rscs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rscs_in_if   i_in,
    rscs_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_dropped,
    output int   o_peak
);

    // Predicted copy of the series: held samples and one split sum per gap.
    logic signed [SAMPLE_W-1:0] series_keys [MAX_SAMPLES];
    int                         split_tally [MAX_SAMPLES];
    int                         held_count  = 0;
    int                         best_so_far = 0;

    t_result results_due [$];
    int      fail_total    = 0;
    int      due_count     = 0;
    int      checked_total = 0;
    int      dropped_total = 0;
    int      peak_best     = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_count;
    assign o_checked    = checked_total;
    assign o_dropped    = dropped_total;
    assign o_peak       = peak_best;

    // Fold one accepted sample into the series and queue the result it yields.
    task automatic scan_sample(input logic signed [SAMPLE_W-1:0] sample,
                               input logic first);
        int      run;
        int      n;
        int      k;
        int      top;
        int      mag;
        logic    dropped;
        t_result r;
        dropped = 1'b0;
        if (first) begin
            held_count  = 0;
            best_so_far = 0;
        end
        if (held_count < MAX_SAMPLES) begin
            // Running sign sum over earlier samples, added to each split it spans.
            run = 0;
            n   = held_count;
            for (k = 0; k < n; k++) begin
                if (series_keys[k] > sample) begin
                    run = run + 1;
                end else if (series_keys[k] < sample) begin
                    run = run - 1;
                end
                if (k + 1 < n) begin
                    split_tally[k] = split_tally[k] + run;
                end
            end
            if (n > 0) begin
                split_tally[n-1] = run;
            end
            series_keys[n] = sample;
            held_count     = n + 1;
        end else begin
            dropped = 1'b1;
        end
        // Largest absolute split sum over the held series.
        top = 0;
        for (k = 0; k + 1 < held_count; k++) begin
            mag = (split_tally[k] < 0) ? -split_tally[k] : split_tally[k];
            if (mag > top) begin
                top = mag;
            end
        end
        if (top > best_so_far) begin
            best_so_far = top;
        end
        r.doubled_stat = top[STAT_W-1:0];
        r.best_doubled = best_so_far[STAT_W-1:0];
        r.sample_count = held_count[COUNT_W-1:0];
        r.full_res     = dropped;
        results_due.insert(results_due.size(), r);
    endtask

    task automatic compare_field(input string label, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            fail_total = fail_total + 1;
        end
    endtask

    // Results are checked before the input of the same edge is predicted, so
    // an early result can never consume the prediction it would have needed.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with nothing expected, got stat %0d count %0d",
                             $time, i_out.doubled_stat, i_out.sample_count);
                    fail_total = fail_total + 1;
                end else begin
                    want = results_due.pop_front();
                    compare_field("doubled_stat", int'(want.doubled_stat),
                                  int'(i_out.doubled_stat));
                    compare_field("best_doubled", int'(want.best_doubled),
                                  int'(i_out.best_doubled));
                    compare_field("sample_count", int'(want.sample_count),
                                  int'(i_out.sample_count));
                    compare_field("full_res", int'(want.full_res), int'(i_out.full_res));
                    checked_total = checked_total + 1;
                    if (want.full_res) begin
                        dropped_total = dropped_total + 1;
                    end
                    if (int'(want.best_doubled) > peak_best) begin
                        peak_best = int'(want.best_doubled);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                scan_sample(i_in.sample, i_in.first);
            end
            due_count = results_due.size();
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import rscs_pkg::*;

    localparam int TAIL_CYCLES    = MAX_SAMPLES + 64;
    localparam int WATCHDOG_LIMIT = 16 * (MAX_SAMPLES + 2);
    localparam int RANDOM_ITEMS   = 125;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int send_idle_pct;
    int take_stall_pct;
    int samples_sent;
    int quiet_cycles = 0;
    int fail_count;
    int pending;
    int checked;
    int dropped;
    int peak;

    rscs_in_if  in_ch ();
    rscs_out_if out_ch ();

    rank_sum_changepoint_scan_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rank_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_dropped    (dropped),
        .o_peak       (peak)
    );

    // Free-running clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side stalls at random according to the current pattern.
    always @(negedge i_clk) begin
        out_ch.ready <= (take_stall_pct == 0) || ($urandom_range(99) >= take_stall_pct);
    end

    // End the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, with random gaps ahead of it, and hold it until taken.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample, input logic first);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.sample <= $urandom();
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= sample;
        in_ch.first  <= first;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        samples_sent = samples_sent + 1;
        @(negedge i_clk);
    endtask

    // Stop sending until every predicted result has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
    endtask

    // Random series: mostly short, some long, with several sample styles.
    task automatic random_phase(input int n_items);
        int                         left;
        int                         series_len;
        int                         idx;
        int                         cut;
        int                         style;
        int                         step;
        logic                       first;
        logic signed [SAMPLE_W-1:0] s;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(9) == 0) begin
                series_len = $urandom_range(200, 60);
            end else begin
                series_len = $urandom_range(30, 1);
            end
            style = $urandom_range(3);
            cut   = $urandom_range(series_len);
            step  = $urandom_range(1) ? 1000 : -1000;
            for (idx = 0; idx < series_len && left > 0; idx++) begin
                case (style)
                    0: s = $urandom();
                    1: s = $signed($urandom_range(6)) - 3;
                    2: s = ((idx < cut) ? 0 : step) + $signed($urandom_range(255));
                    default: begin
                        case ($urandom_range(3))
                            0: s = {1'b1, {(SAMPLE_W-1){1'b0}}};
                            1: s = {1'b0, {(SAMPLE_W-1){1'b1}}};
                            2: s = '0;
                            default: s = '1;
                        endcase
                    end
                endcase
                // A new series usually raises first; now and then it does not,
                // and a stray first can cut a series short.
                first = (idx == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
                send_sample(s, first);
                left = left - 1;
            end
        end
    endtask

    initial begin
        int k;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.sample   = '0;
        in_ch.first    = 1'b0;
        send_idle_pct  = 0;
        take_stall_pct = 0;
        samples_sent   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: a series right after reset without first, field extremes,
        // equal samples, and new series that start mid-stream.
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('0, 1'b0);
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'shAAAA_AAAA, 1'b0);
        send_sample(1, 1'b1);
        send_sample(1, 1'b1);
        send_sample(7, 1'b1);
        send_sample(7, 1'b0);
        send_sample(3, 1'b0);
        send_sample(9, 1'b0);
        send_sample(-5, 1'b0);
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b1);
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
        wait_drained();

        // Fill the store with a falling series so the middle split reaches the
        // top of the statistic, then keep sending so samples are dropped.
        send_idle_pct  = 31;
        take_stall_pct = 31;
        send_sample(32'sh7FF0_0000, 1'b1);
        for (k = 1; k < MAX_SAMPLES; k++) begin
            send_sample(32'sh7FF0_0000 - (k <<< 16), 1'b0);
        end
        for (k = 0; k < 4; k++) begin
            send_sample($urandom(), 1'b0);
        end
        wait_drained();

        // Random series under each handshake pattern, draining between them.
        send_idle_pct  = 0;
        take_stall_pct = 0;
        random_phase(RANDOM_ITEMS);
        wait_drained();
        send_idle_pct  = 49;
        take_stall_pct = 0;
        random_phase(RANDOM_ITEMS);
        wait_drained();
        send_idle_pct  = 0;
        take_stall_pct = 49;
        random_phase(RANDOM_ITEMS);
        wait_drained();
        send_idle_pct  = 31;
        take_stall_pct = 31;
        random_phase(RANDOM_ITEMS);
        wait_drained();

        // Let any stray result surface before the verdict.
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d samples under four handshake patterns, %0d results checked.",
                 samples_sent, checked);
        $display("%0d results reported a full store; largest best statistic seen %0d.",
                 dropped, peak);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
